>>> src/crc16_frame_deframer_assert.svh
// assertion helpers for the crc16 frame deframer
`ifndef CRC16_FRAME_DEFRAMER_ASSERT_SVH
`define CRC16_FRAME_DEFRAMER_ASSERT_SVH

// same-cycle implication
`define CRCFD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("crcfd: same-cycle check failed");

// next-cycle implication
`define CRCFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("crcfd: next-cycle check failed");

`endif

>>> src/crcfd_pkg.sv
package crcfd_pkg;

  localparam int HDR_LEN = 11;
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_DATA_W = 152;

  // header byte positions
  localparam logic [3:0] HDR_MAGIC    = 4'd0;
  localparam logic [3:0] HDR_VERSION  = 4'd1;
  localparam logic [3:0] HDR_MSG_TYPE = 4'd2;
  localparam logic [3:0] HDR_COMMAND  = 4'd3;
  localparam logic [3:0] HDR_SEQ_HI   = 4'd4;
  localparam logic [3:0] HDR_SEQ_LO   = 4'd5;
  localparam logic [3:0] HDR_FLAGS    = 4'd6;
  localparam logic [3:0] HDR_FRAG_IDX = 4'd7;
  localparam logic [3:0] HDR_FRAG_TOT = 4'd8;
  localparam logic [3:0] HDR_LEN_HI   = 4'd9;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAGIC    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERSION  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENC_MASK = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN  = 8'd3;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_MSB  = 16'h8000;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_TAG     = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_CRC_BAD = 2'd2
  } status_t;

  typedef struct packed {
    kind_t        kind;
    logic [7:0]   out_byte;
    status_t      status;
    logic [7:0]   message_type;
    logic [7:0]   command_code;
    logic [15:0]  sequence_res;
    logic [7:0]   flag_bits;
    logic [15:0]  body_len;
    logic         encrypted;
    logic [63:0]  security_count;
    logic [15:0]  frame_total;
  } res_t;

  // handshake between queue and its neighbors
  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> src/crcfd_front.sv
module crcfd_front #(
  parameter int COUNTER_BYTES = 8,
  parameter int TAG_BYTES = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_byte,
  input  logic                              in_last,
  input  logic                              cfg_valid,
  input  logic [crcfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [crcfd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  crcfd_pkg::q_stat_t                q_stat,
  output logic                              push,
  output crcfd_pkg::res_t                   push_res
);
  import crcfd_pkg::*;

  localparam int CW = 8 * COUNTER_BYTES;

  logic [7:0]  magic_value;
  logic [7:0]  version_value;
  logic [7:0]  encrypted_mask;
  logic [15:0] min_frame_len;

  logic [15:0]   byte_index, byte_index_next;
  logic [15:0]   running_crc, running_crc_next;
  logic          header_bad, header_bad_next;
  logic [7:0]    hdr_message_type, hdr_message_type_next;
  logic [7:0]    hdr_command, hdr_command_next;
  logic [15:0]   hdr_sequence, hdr_sequence_next;
  logic [7:0]    hdr_flags, hdr_flags_next;
  logic [15:0]   hdr_body_len, hdr_body_len_next;
  logic [CW-1:0] counter_value, counter_value_next;
  logic [15:0]   received_crc, received_crc_next;

  logic          accept;
  logic          enc_cur, enc_nxt;
  logic [17:0]   cnt_end, pay_end, crc_off, idx_ext;
  logic [17:0]   cnt_end_n, total_n;
  logic [CW+7:0] counter_shift;
  logic          stream_en;
  kind_t         stream_kind;
  logic          invalid, crc_ok;

  assign in_ready = !q_stat.full;
  assign accept = in_valid && in_ready;
  assign push = accept && (in_last || stream_en);

  always_comb begin
    // layout from the header as it stands before this byte
    enc_cur = (hdr_flags & encrypted_mask) != 8'h00;
    cnt_end = 18'(HDR_LEN) + (enc_cur ? 18'(COUNTER_BYTES) : 18'd0);
    pay_end = cnt_end + {2'b00, hdr_body_len};
    crc_off = pay_end + (enc_cur ? 18'(TAG_BYTES) : 18'd0);
    idx_ext = {2'b00, byte_index};
    counter_shift = {counter_value, in_byte};

    byte_index_next = (byte_index != 16'hFFFF) ? byte_index + 16'd1 : byte_index;
    running_crc_next = running_crc;
    header_bad_next = header_bad;
    hdr_message_type_next = hdr_message_type;
    hdr_command_next = hdr_command;
    hdr_sequence_next = hdr_sequence;
    hdr_flags_next = hdr_flags;
    hdr_body_len_next = hdr_body_len;
    counter_value_next = counter_value;
    received_crc_next = received_crc;
    stream_en = 1'b0;
    stream_kind = KIND_PAYLOAD;

    if (idx_ext < 18'(HDR_LEN)) begin
      running_crc_next = crc16_byte(running_crc, in_byte);
      case (byte_index[3:0])
        HDR_MAGIC:    header_bad_next = header_bad || (in_byte != magic_value);
        HDR_VERSION:  header_bad_next = header_bad || (in_byte != version_value);
        HDR_MSG_TYPE: hdr_message_type_next = in_byte;
        HDR_COMMAND:  hdr_command_next = in_byte;
        HDR_SEQ_HI:   hdr_sequence_next = {in_byte, 8'h00};
        HDR_SEQ_LO:   hdr_sequence_next = {hdr_sequence[15:8], in_byte};
        HDR_FLAGS:    hdr_flags_next = in_byte;
        HDR_FRAG_IDX: header_bad_next = header_bad || (in_byte != 8'd0);
        HDR_FRAG_TOT: header_bad_next = header_bad || (in_byte != 8'd1);
        HDR_LEN_HI:   hdr_body_len_next = {in_byte, 8'h00};
        default:      hdr_body_len_next = {hdr_body_len[15:8], in_byte};
      endcase
    end else if (idx_ext < crc_off) begin
      running_crc_next = crc16_byte(running_crc, in_byte);
      if (idx_ext < cnt_end) begin
        counter_value_next = counter_shift[CW-1:0];
      end else if (idx_ext < pay_end) begin
        stream_en = 1'b1;
        stream_kind = KIND_PAYLOAD;
      end else begin
        stream_en = 1'b1;
        stream_kind = KIND_TAG;
      end
    end else if (idx_ext < crc_off + 18'd2) begin
      received_crc_next = {received_crc[7:0], in_byte};
    end

    // summary view uses the state after this byte
    enc_nxt = (hdr_flags_next & encrypted_mask) != 8'h00;
    cnt_end_n = 18'(HDR_LEN) + (enc_nxt ? 18'(COUNTER_BYTES) : 18'd0);
    total_n = cnt_end_n + {2'b00, hdr_body_len_next} + (enc_nxt ? 18'(TAG_BYTES) : 18'd0)
              + 18'd2;
    invalid = (byte_index_next < min_frame_len) || (byte_index_next < 16'(HDR_LEN))
              || header_bad_next || ({2'b00, byte_index_next} < total_n);
    crc_ok = received_crc_next == running_crc_next;

    push_res = '0;
    if (in_last) begin
      push_res.kind = KIND_SUMMARY;
      if (invalid) begin
        push_res.status = ST_INVALID;
      end else begin
        push_res.status = crc_ok ? ST_OK : ST_CRC_BAD;
        push_res.message_type = hdr_message_type_next;
        push_res.command_code = hdr_command_next;
        push_res.sequence_res = hdr_sequence_next;
        push_res.flag_bits = hdr_flags_next;
        push_res.body_len = hdr_body_len_next;
        push_res.encrypted = enc_nxt;
        push_res.security_count = enc_nxt ? 64'(counter_value_next) : 64'd0;
        push_res.frame_total = crc_ok ? total_n[15:0] : 16'd0;
      end
    end else begin
      push_res.kind = stream_kind;
      push_res.out_byte = in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_value <= 8'd0;
      version_value <= 8'd0;
      encrypted_mask <= 8'd1;
      min_frame_len <= 16'd13;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAGIC:    magic_value <= cfg_data[7:0];
        REG_VERSION:  version_value <= cfg_data[7:0];
        REG_ENC_MASK: encrypted_mask <= cfg_data[7:0];
        REG_MIN_LEN:  min_frame_len <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && in_last)) begin
      byte_index <= 16'd0;
      running_crc <= CRC_INIT;
      header_bad <= 1'b0;
      hdr_message_type <= 8'd0;
      hdr_command <= 8'd0;
      hdr_sequence <= 16'd0;
      hdr_flags <= 8'd0;
      hdr_body_len <= 16'd0;
      counter_value <= '0;
      received_crc <= 16'd0;
    end else if (accept) begin
      byte_index <= byte_index_next;
      running_crc <= running_crc_next;
      header_bad <= header_bad_next;
      hdr_message_type <= hdr_message_type_next;
      hdr_command <= hdr_command_next;
      hdr_sequence <= hdr_sequence_next;
      hdr_flags <= hdr_flags_next;
      hdr_body_len <= hdr_body_len_next;
      counter_value <= counter_value_next;
      received_crc <= received_crc_next;
    end
  end

endmodule

>>> src/crcfd_queue.sv
module crcfd_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  crcfd_pkg::res_t     push_res,
  input  logic                pop,
  output crcfd_pkg::res_t     head_res,
  output crcfd_pkg::q_stat_t  q_stat
);
  import crcfd_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  res_t            entries [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNTW-1:0] q_count;
  logic            do_push, do_pop;

  assign q_stat.full = q_count == CNTW'(QUEUE_DEPTH);
  assign q_stat.valid = q_count != '0;
  assign head_res = entries[rd_ptr];
  assign do_push = push && !q_stat.full;
  assign do_pop = pop && q_stat.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      q_count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        q_count <= q_count + CNTW'(1);
      end else if (do_pop && !do_push) begin
        q_count <= q_count - CNTW'(1);
      end
    end
  end

  `include "crc16_frame_deframer_assert.svh"

  // the parser must hold off while the queue is full
  `CRCFD_ASSERT_NOW(a_no_push_full, clk, rst, push, !q_stat.full)
  `CRCFD_ASSERT_NOW(a_no_pop_empty, clk, rst, pop, q_stat.valid)
  `CRCFD_ASSERT_NEXT(a_count_up, clk, rst, do_push && !do_pop, q_count == $past(q_count) + CNTW'(1))
  `CRCFD_ASSERT_NEXT(a_count_down, clk, rst, do_pop && !do_push, q_count == $past(q_count) - CNTW'(1))

endmodule

>>> src/crcfd_back.sv
module crcfd_back (
  input  logic                               clk,
  input  logic                               rst,
  input  crcfd_pkg::q_stat_t                 q_stat,
  input  crcfd_pkg::res_t                    head_res,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [crcfd_pkg::OUT_DATA_W-1:0]   out_data,
  output logic [1:0]                         out_user
);
  import crcfd_pkg::*;

  res_t out_res;

  assign pop = q_stat.valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_res <= head_res;
    end
  end

  assign out_data = {5'b00000, out_res.frame_total, out_res.security_count,
                     out_res.encrypted, out_res.body_len, out_res.flag_bits,
                     out_res.sequence_res, out_res.command_code, out_res.message_type,
                     out_res.status, out_res.out_byte};
  assign out_user = out_res.kind;

endmodule

>>> src/crc16_frame_deframer.sv
// crc16 frame deframer
// s_axis carries the received frame one byte per transaction, tlast on the
// final byte. m_axis gives one result per payload or tag byte and one frame
// summary when the tlast byte is taken; header, counter and crc bytes give
// no result. tuser says what the result is: payload byte, tag byte or summary.
// cfg writes one of magic, version, encrypted mask or minimum length; write it
// only while no frame is in flight. cfg_ready is always high.
// throughput: one byte per cycle while the queue is not full, bounded by the
// crc byte update and field capture in the parser. a result passes through
// the queue entry and then the output register before it is valid on m_axis.
// a two-entry queue and the output register sit between parser and output;
// when m_axis stalls, s_axis keeps taking bytes until the queue fills, then
// s_axis_tready drops until the receiver takes a result.
// reset clears all frame state and loads the register defaults; no results
// are pending after reset. stream bytes are sent even for frames that end
// invalid; the receiver drops them on a bad summary status.
module crc16_frame_deframer #(
  parameter int COUNTER_BYTES = 8,
  parameter int TAG_BYTES = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,   // data_byte
  input  logic                              s_axis_tlast,   // last_byte
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_byte, status, message_type, command_code, sequence_res, flag_bits,
  // body_len, encrypted, security_count, frame_total, zero fill
  output logic [crcfd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic [1:0]                        m_axis_tuser,   // kind
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [crcfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [crcfd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import crcfd_pkg::*;

  q_stat_t q_stat;
  logic    push;
  res_t    push_res;
  logic    pop;
  res_t    head_res;

  assign cfg_ready = 1'b1;

  crcfd_front #(
    .COUNTER_BYTES(COUNTER_BYTES),
    .TAG_BYTES(TAG_BYTES)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .in_byte(s_axis_tdata),
    .in_last(s_axis_tlast),
    .cfg_valid(cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .q_stat(q_stat),
    .push(push),
    .push_res(push_res)
  );

  crcfd_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_res(push_res),
    .pop(pop),
    .head_res(head_res),
    .q_stat(q_stat)
  );

  crcfd_back u_back (
    .clk(clk),
    .rst(rst),
    .q_stat(q_stat),
    .head_res(head_res),
    .pop(pop),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data(m_axis_tdata),
    .out_user(m_axis_tuser)
  );

endmodule

>>> tb/deframer_result_checker.sv
module deframer_result_checker #(
  parameter int COUNTER_BYTES = 8,
  parameter int TAG_BYTES = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,
  input  logic                              s_axis_tlast,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [crcfd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic [1:0]                        m_axis_tuser,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [crcfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [crcfd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                                outstanding,
  output int                                error_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import crcfd_pkg::*;

  // m_axis_tdata as seen on the bus, last field in the lowest bits
  typedef struct packed {
    logic [4:0]  fill;
    logic [15:0] frame_total;
    logic [63:0] security_count;
    logic        encrypted;
    logic [15:0] body_len;
    logic [7:0]  flag_bits;
    logic [15:0] sequence_res;
    logic [7:0]  command_code;
    logic [7:0]  message_type;
    logic [1:0]  status;
    logic [7:0]  out_byte;
  } result_beat_t;

  // register copies
  logic [7:0]  magic_cfg;
  logic [7:0]  version_cfg;
  logic [7:0]  enc_mask_cfg;
  logic [15:0] min_len_cfg;

  // frame parse state
  logic [15:0] pos;
  logic [15:0] crc_acc;
  logic        hdr_err;
  logic [7:0]  f_type;
  logic [7:0]  f_cmd;
  logic [15:0] f_seq;
  logic [7:0]  f_flags;
  logic [15:0] f_len;
  logic [63:0] sec_ctr;
  logic [15:0] crc_rx;

  res_t predicted_results[$];

  function automatic logic [15:0] crc_ccitt_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic fb;
    c = crc;
    for (int k = 7; k >= 0; k--) begin
      fb = c[15] ^ b[k];
      c = {c[14:0], 1'b0};
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  task automatic clear_frame();
    pos = '0;
    crc_acc = CRC_INIT;
    hdr_err = 1'b0;
    f_type = '0;
    f_cmd = '0;
    f_seq = '0;
    f_flags = '0;
    f_len = '0;
    sec_ctr = '0;
    crc_rx = '0;
  endtask

  task automatic deframe_byte(input logic [7:0] b, input logic last);
    int unsigned idx;
    int unsigned ctr_end;
    int unsigned pay_end;
    int unsigned crc_at;
    int unsigned count;
    bit enc;
    bit streamed;
    res_t r;
    r = '0;
    streamed = 1'b0;
    idx = pos;
    enc = (f_flags & enc_mask_cfg) != 8'h00;
    ctr_end = HDR_LEN + (enc ? COUNTER_BYTES : 0);
    pay_end = ctr_end + f_len;
    crc_at = pay_end + (enc ? TAG_BYTES : 0);

    if (idx < HDR_LEN) begin
      crc_acc = crc_ccitt_next(crc_acc, b);
      case (idx)
        HDR_MAGIC: if (b != magic_cfg) hdr_err = 1'b1;
        HDR_VERSION: if (b != version_cfg) hdr_err = 1'b1;
        HDR_MSG_TYPE: f_type = b;
        HDR_COMMAND: f_cmd = b;
        HDR_SEQ_HI: f_seq = {b, 8'h00};
        HDR_SEQ_LO: f_seq[7:0] = b;
        HDR_FLAGS: f_flags = b;
        HDR_FRAG_IDX: if (b != 8'd0) hdr_err = 1'b1;
        HDR_FRAG_TOT: if (b != 8'd1) hdr_err = 1'b1;
        HDR_LEN_HI: f_len = {b, 8'h00};
        default: f_len[7:0] = b;
      endcase
    end else if (idx < crc_at) begin
      crc_acc = crc_ccitt_next(crc_acc, b);
      if (idx < ctr_end) begin
        sec_ctr = {sec_ctr[55:0], b};
      end else begin
        streamed = 1'b1;
        r.kind = (idx < pay_end) ? KIND_PAYLOAD : KIND_TAG;
        r.out_byte = b;
      end
    end else if (idx < crc_at + 2) begin
      crc_rx = {crc_rx[7:0], b};
    end

    // the byte count sticks at its maximum
    if (pos != 16'hFFFF) pos = pos + 16'd1;

    if (last) begin
      count = pos;
      enc = (f_flags & enc_mask_cfg) != 8'h00;
      crc_at = HDR_LEN + (enc ? COUNTER_BYTES : 0) + f_len + (enc ? TAG_BYTES : 0);
      r = '0;
      r.kind = KIND_SUMMARY;
      if (count < min_len_cfg || count < HDR_LEN || hdr_err || count < crc_at + 2) begin
        r.status = ST_INVALID;
      end else begin
        r.status = (crc_rx == crc_acc) ? ST_OK : ST_CRC_BAD;
        r.message_type = f_type;
        r.command_code = f_cmd;
        r.sequence_res = f_seq;
        r.flag_bits = f_flags;
        r.body_len = f_len;
        r.encrypted = enc;
        r.security_count = enc ? sec_ctr : 64'd0;
        r.frame_total = (crc_rx == crc_acc) ? 16'(crc_at + 2) : 16'd0;
      end
      predicted_results.push_back(r);
      clear_frame();
    end else if (streamed) begin
      predicted_results.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  task automatic check_result();
    res_t want;
    result_beat_t got;
    if (predicted_results.size() == 0) begin
      $error("result transaction with nothing predicted, tuser %0d", m_axis_tuser);
      error_count++;
    end else begin
      want = predicted_results.pop_front();
      got = m_axis_tdata;
      check_field("kind", want.kind, m_axis_tuser);
      check_field("out_byte", want.out_byte, got.out_byte);
      check_field("status", want.status, got.status);
      check_field("message_type", want.message_type, got.message_type);
      check_field("command_code", want.command_code, got.command_code);
      check_field("sequence_res", want.sequence_res, got.sequence_res);
      check_field("flag_bits", want.flag_bits, got.flag_bits);
      check_field("body_len", want.body_len, got.body_len);
      check_field("encrypted", want.encrypted, got.encrypted);
      check_field("security_count", want.security_count, got.security_count);
      check_field("frame_total", want.frame_total, got.frame_total);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      magic_cfg = 8'h00;
      version_cfg = 8'h00;
      enc_mask_cfg = 8'h01;
      min_len_cfg = 16'd13;
      clear_frame();
      predicted_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MAGIC: magic_cfg = cfg_data[7:0];
          REG_VERSION: version_cfg = cfg_data[7:0];
          REG_ENC_MASK: enc_mask_cfg = cfg_data[7:0];
          REG_MIN_LEN: min_len_cfg = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) deframe_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) check_result();
    end
    outstanding = predicted_results.size();
  end

endmodule

>>> tb/tb_crc16_frame_deframer.sv
module tb_crc16_frame_deframer;
  timeunit 1ns;
  timeprecision 1ps;
  import crcfd_pkg::*;

  localparam int CTR_BYTES = 8;
  localparam int TAG_LEN = 8;
  localparam int RX_HOLD_CYCLES = 150;
  localparam int STALL_LIMIT = 2000;

  typedef enum int {
    FR_GOOD,
    FR_BAD_CRC,
    FR_BAD_MAGIC,
    FR_BAD_VERSION,
    FR_BAD_FRAG_IDX,
    FR_BAD_FRAG_TOT,
    FR_TRUNC
  } frame_fault_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = 8'h00;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0]            m_axis_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int outstanding;
  int chk_errors;

  // register values the frame builder must match
  logic [7:0]  cur_magic = 8'h00;
  logic [7:0]  cur_version = 8'h00;
  logic [7:0]  cur_mask = 8'h01;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int items_sent = 0;
  logic hold_toggle = 1'b0;
  logic hold_seen = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  logic [7:0] frame_buf[$];

  crc16_frame_deframer #(
    .COUNTER_BYTES(CTR_BYTES),
    .TAG_BYTES(TAG_LEN)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  deframer_result_checker #(
    .COUNTER_BYTES(CTR_BYTES),
    .TAG_BYTES(TAG_LEN)
  ) result_chk (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .outstanding(outstanding),
    .error_count(chk_errors)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // receiver: random idling, plus a long hold-off each time hold_toggle flips
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_seen <= hold_toggle;
      hold_left <= 0;
    end else if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= RX_HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [15:0] frame_crc();
    logic [15:0] c;
    c = CRC_INIT;
    foreach (frame_buf[i]) begin
      c = c ^ {frame_buf[i], 8'h00};
      repeat (8) c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  task automatic build_frame(input frame_fault_t fault, input int plen, input bit want_enc);
    logic [7:0] flags;
    logic [15:0] crc;
    bit enc;
    int cut;
    flags = 8'($urandom_range(255));
    if (want_enc && cur_mask != 8'h00) begin
      while ((flags & cur_mask) == 8'h00) flags = 8'($urandom_range(255));
    end else begin
      flags = flags & ~cur_mask;
    end
    enc = (flags & cur_mask) != 8'h00;
    frame_buf.delete();
    frame_buf.push_back((fault == FR_BAD_MAGIC) ? cur_magic ^ 8'($urandom_range(1, 255))
                                                : cur_magic);
    frame_buf.push_back((fault == FR_BAD_VERSION) ? cur_version ^ 8'($urandom_range(1, 255))
                                                  : cur_version);
    repeat (4) frame_buf.push_back(8'($urandom_range(255)));
    frame_buf.push_back(flags);
    frame_buf.push_back((fault == FR_BAD_FRAG_IDX) ? 8'($urandom_range(1, 255)) : 8'd0);
    frame_buf.push_back((fault == FR_BAD_FRAG_TOT) ? 8'd1 ^ 8'($urandom_range(1, 255)) : 8'd1);
    frame_buf.push_back(8'(plen >> 8));
    frame_buf.push_back(8'(plen));
    if (enc) repeat (CTR_BYTES) frame_buf.push_back(8'($urandom_range(255)));
    repeat (plen) frame_buf.push_back(8'($urandom_range(255)));
    if (enc) repeat (TAG_LEN) frame_buf.push_back(8'($urandom_range(255)));
    crc = frame_crc();
    if (fault == FR_BAD_CRC) crc = crc ^ 16'($urandom_range(1, 65535));
    frame_buf.push_back(crc[15:8]);
    frame_buf.push_back(crc[7:0]);
    if (fault == FR_TRUNC) begin
      // last byte may land in the header, counter, payload, tag or crc
      cut = $urandom_range(1, frame_buf.size() - 1);
      while (frame_buf.size() > cut) void'(frame_buf.pop_back());
    end else if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 3)) frame_buf.push_back(8'($urandom_range(255)));
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_buf[i]) send_byte(frame_buf[i], i == frame_buf.size() - 1);
  endtask

  // sender stops until every predicted result is out, then lets trailing bytes settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    // the prediction of the last accepted byte is counted from the next edge on
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [7:0] magic, input logic [7:0] version,
                               input logic [7:0] mask, input logic [15:0] min_len);
    logic [CFG_IDX_W-1:0] idx[4];
    logic [CFG_DATA_W-1:0] val[4];
    wait_idle();
    idx = '{REG_MAGIC, REG_VERSION, REG_ENC_MASK, REG_MIN_LEN};
    // upper byte of the 8-bit registers is random and must be dropped
    val = '{{8'($urandom_range(255)), magic}, {8'($urandom_range(255)), version},
            {8'($urandom_range(255)), mask}, min_len};
    for (int k = 0; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data <= val[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    cur_magic = magic;
    cur_version = version;
    cur_mask = mask;
  endtask

  task automatic run_random(input int n_items);
    int stop_at;
    int pick;
    int plen;
    frame_fault_t fault;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      plen = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(12);
      if (pick < 55) fault = FR_GOOD;
      else if (pick < 65) fault = FR_BAD_CRC;
      else if (pick < 69) fault = FR_BAD_MAGIC;
      else if (pick < 73) fault = FR_BAD_VERSION;
      else if (pick < 77) fault = FR_BAD_FRAG_IDX;
      else if (pick < 81) fault = FR_BAD_FRAG_TOT;
      else fault = FR_TRUNC;
      if (pick >= 92) begin
        // line noise
        frame_buf.delete();
        repeat ($urandom_range(1, 40)) frame_buf.push_back(8'($urandom_range(255)));
      end else begin
        build_frame(fault, plen, $urandom_range(1));
      end
      send_frame();
      if ($urandom_range(19) == 0) wait_idle();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    tx_idle_pct = 34;
    rx_idle_pct = 49;

    // frame ending inside the header, smallest plain frame, encrypted frame with one payload byte
    frame_buf.delete();
    frame_buf.push_back(8'hFF);
    send_frame();
    build_frame(FR_GOOD, 0, 1'b0);
    send_frame();
    build_frame(FR_GOOD, 1, 1'b1);
    send_frame();

    hold_toggle <= ~hold_toggle;
    build_frame(FR_GOOD, 40, 1'b1);
    send_frame();
    run_random(150);

    apply_setting(8'hA5, 8'h3C, 8'h81, 16'd0);
    run_random(150);

    tx_idle_pct = 49;
    rx_idle_pct = 34;
    apply_setting(8'hFF, 8'hFF, 8'hFF, 16'd40);
    hold_toggle <= ~hold_toggle;
    build_frame(FR_GOOD, 40, 1'b0);
    send_frame();
    run_random(200);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    apply_setting(8'h00, 8'h00, 8'h00, 16'd13);
    run_random(100);

    apply_setting(8'h5A, 8'h80, 8'h80, 16'hFFFF);
    run_random(40);
    // minimum length above any frame sent here
    build_frame(FR_GOOD, 10, 1'b0);
    send_frame();

    wait_idle();
    if (chk_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
